### rtl/itml_pkg.sv
// ----------------------------------------------------------------------------
// itml_pkg: shared constants, types and helpers
// Fixed-point constants of the curves, the log10 mapping and the exp2 series.
// ----------------------------------------------------------------------------
package itml_pkg;

	localparam int IN_FRAC_BITS_DEF  = 16;
	localparam int OUT_FRAC_BITS_DEF = 20;

	// config register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_BYTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE      = 1'd1;

	// all Q.24 unless noted
	localparam int ONE_Q24     = 16777216;
	localparam int BREAK_Q24   = 16663131;
	localparam int RANGE_Q24   = 55638642;
	localparam int MINV_Q24    = -36113449;
	localparam int LOG2_10_Q24 = 55732705;
	localparam logic [29:0] C018_Q30 = 30'd193273528;

	localparam int FRAC = 24;     // curve fraction bits
	localparam int CW   = 28;     // curve coefficient width
	localparam int C0W  = 25;     // leading gain coefficient width
	localparam int RSW  = 96;     // width of the rounding helper

	localparam logic signed [CW-1:0] LOW_COEF [8] = '{
		28'sd4109173, -28'sd10602534, -28'sd71333235, 28'sd64453390,
		-28'sd83933, -28'sd8808212, -28'sd14848147, 28'sd19346706
	};
	localparam logic signed [CW-1:0] HIGH_COEF [8] = '{
		28'sd8630164, -28'sd9282269, -28'sd44923931, 28'sd48713380,
		-28'sd84848, -28'sd13504160, -28'sd23944221, 28'sd34710557
	};

	// (ln 2)^k / k! in Q.30, k = 1..8
	localparam int EXP_TERMS = 8;
	localparam logic [29:0] EXP2_COEF [EXP_TERMS] = '{
		30'd744261118, 30'd257941248, 30'd59597083, 30'd10327387,
		30'd1431680, 30'd165394, 30'd16377, 30'd1419
	};

	// early result of the curve division
	typedef struct packed {
		logic bypass;   // result known without dividing
		logic one;      // bypass value: 1.0 when set, else 0
	} itml_byp_t;

	function automatic logic signed [CW-1:0] coef(input logic hi, input int k);
		coef = hi ? HIGH_COEF[k] : LOW_COEF[k];
	endfunction

	// divide by 2^24, round half away from zero
	function automatic logic signed [RSW-1:0] rnd_shift24(input logic signed [RSW-1:0] v);
		logic [RSW-1:0] mag;
		logic [RSW-1:0] r;
		mag = v[RSW-1] ? RSW'(-v) : RSW'(v);
		r = (mag + (RSW'(1) << (FRAC - 1))) >> FRAC;
		rnd_shift24 = v[RSW-1] ? -$signed(r) : $signed(r);
	endfunction

endpackage

### rtl/itml_div.sv
// ----------------------------------------------------------------------------
// itml_div: pipelined restoring divider
// One quotient bit per stage; numerator below den << QUO_W when not bypassed.
// ----------------------------------------------------------------------------
module itml_div #(
	parameter int DEN_W = 41,
	parameter int QUO_W = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [DEN_W+QUO_W-1:0] num,
	input  logic [DEN_W-1:0]       den,
	input  itml_pkg::itml_byp_t    byp,
	output logic                   out_valid,
	output logic [QUO_W:0]         ratio
);

	localparam int RMW = DEN_W + QUO_W;

	logic [RMW-1:0]      rem_s [QUO_W];
	logic [DEN_W-1:0]    den_s [QUO_W];
	logic [QUO_W-1:0]    quo_s [QUO_W];
	itml_pkg::itml_byp_t byp_s [QUO_W];
	logic                v_s   [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int B = QUO_W - 1 - i;
		logic [RMW-1:0]      rem_in;
		logic [DEN_W-1:0]    den_in;
		logic [QUO_W-1:0]    quo_in;
		itml_pkg::itml_byp_t byp_in;
		logic                v_in;
		logic [RMW-1:0]      dsh;
		logic                ge;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign byp_in = byp;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign byp_in = byp_s[i-1];
			assign v_in   = v_s[i-1];
		end

		assign dsh = RMW'(den_in) << B;
		assign ge  = rem_in >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? rem_in - dsh : rem_in;
				den_s[i] <= den_in;
				quo_s[i] <= quo_in | (ge ? (QUO_W'(1) << B) : '0);
				byp_s[i] <= byp_in;
			end
		end
	end

	assign out_valid = v_s[QUO_W-1];
	assign ratio = byp_s[QUO_W-1].bypass ?
		(byp_s[QUO_W-1].one ? ((QUO_W+1)'(1) << QUO_W) : '0) :
		{1'b0, quo_s[QUO_W-1]};

endmodule

### rtl/itml_exp2.sv
// ----------------------------------------------------------------------------
// itml_exp2: pipelined 2^f times 0.18
// Horner steps of a degree-8 series in Q.30, one multiply per stage.
// ----------------------------------------------------------------------------
module itml_exp2 #(
	parameter int NXW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [23:0]           frac,
	input  logic signed [NXW-1:0] ipart,
	output logic                  out_valid,
	output logic [31:0]           mant,
	output logic signed [NXW-1:0] ipart_out
);

	localparam int NST = itml_pkg::EXP_TERMS + 1;   // 8 Horner steps + scale

	logic [31:0]           p_s  [NST];
	logic [29:0]           fq_s [NST];
	logic signed [NXW-1:0] n_s  [NST];
	logic                  v_s  [NST];

	for (genvar j = 0; j < NST; j++) begin : g_stage
		logic [31:0]           p_in;
		logic [29:0]           fq_in;
		logic signed [NXW-1:0] n_in;
		logic                  v_in;
		logic [63:0]           prod;
		logic [31:0]           p_nx;

		if (j == 0) begin : g_first
			assign p_in  = 32'(itml_pkg::EXP2_COEF[itml_pkg::EXP_TERMS-1]);
			assign fq_in = {frac, 6'b0};
			assign n_in  = ipart;
			assign v_in  = in_valid;
		end else begin : g_next
			assign p_in  = p_s[j-1];
			assign fq_in = fq_s[j-1];
			assign n_in  = n_s[j-1];
			assign v_in  = v_s[j-1];
		end

		if (j < itml_pkg::EXP_TERMS - 1) begin : g_horner
			assign prod = 64'(p_in) * 64'(fq_in);
			assign p_nx = 32'(itml_pkg::EXP2_COEF[itml_pkg::EXP_TERMS-2-j])
				+ 32'((prod + (64'd1 << 29)) >> 30);
		end else if (j == itml_pkg::EXP_TERMS - 1) begin : g_last
			assign prod = 64'(p_in) * 64'(fq_in);
			assign p_nx = (32'd1 << 30) + 32'((prod + (64'd1 << 29)) >> 30);
		end else begin : g_scale
			assign prod = 64'(p_in) * 64'(itml_pkg::C018_Q30);
			assign p_nx = 32'((prod + (64'd1 << 29)) >> 30);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[j]  <= p_nx;
				fq_s[j] <= fq_in;
				n_s[j]  <= n_in;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign mant      = p_s[NST-1];
	assign ipart_out = n_s[NST-1];

endmodule

### rtl/inverse_tone_map_linearizer_unit.sv
// ----------------------------------------------------------------------------
// inverse_tone_map_linearizer_unit: display sample to linear radiance
// Rational-cubic inverse tone curve, log10 mapping and exposure scaling.
// ----------------------------------------------------------------------------
// Takes one channel sample per beat and returns 0.18 * 10^v / 2^exposure as
// unsigned Q(32-OUT_FRAC_BITS).OUT_FRAC_BITS, where v is the clamped curve
// value mapped onto the log10 range [-2.1525, 1.1638]. The input is a byte
// (value/255) or a signed Q3.IN_FRAC_BITS number, as input_is_byte selects.
// The unit is fully pipelined, one beat per clock in and out while the skid
// entry is free: 9 curve stages, 24 one-bit divider stages, 5 log/exponent
// stages, 9 exp2 stages, output register; the divider is the longest part.
// A two-entry output buffer (output register plus skid) keeps the input
// flowing after the output stalls until a result lands in the skid. Results
// that overflow the output range read all ones, flagged saturated in m_tuser.
// ----------------------------------------------------------------------------
module inverse_tone_map_linearizer_unit #(
	parameter int IN_FRAC_BITS  = itml_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = itml_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write port
	input  logic                           cfg_we,
	input  logic [itml_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [itml_pkg::CFG_DATA_W-1:0] cfg_data,
	// sample in
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,   // [18:0] sample
	// result out
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [31:0] linear_value
	output logic [0:0]                     m_tuser    // [0] saturated
);

	localparam int FRAC = itml_pkg::FRAC;
	localparam int RSW  = itml_pkg::RSW;
	localparam int XSH  = FRAC - IN_FRAC_BITS;
	localparam int XW   = (43 - IN_FRAC_BITS > 26) ? 43 - IN_FRAC_BITS : 26;
	localparam int X2W  = 2 * XW - 24;
	localparam int X3W  = 3 * XW - 49;
	localparam int CW   = itml_pkg::CW;
	localparam int C0W  = itml_pkg::C0W;
	localparam int PRW  = CW + X3W;          // coefficient product
	localparam int SUMW = PRW + 2;           // sum of three products
	localparam int NW   = SUMW - 22;         // rounded numerator
	localparam int DNW  = NW + 1;            // denominator
	localparam int PW   = C0W + NW;          // gain times numerator
	localparam int RMW  = DNW + FRAC;        // divider remainder
	localparam int CMPW = (PW > RMW) ? PW : RMW;
	localparam int LVW  = 28;
	localparam int EW   = 34;
	localparam int NXW  = EW - FRAC;

	localparam logic signed [XW-1:0] BRK = XW'(itml_pkg::BREAK_Q24);

	// ---------------- config registers ----------------
	logic              byte_q;
	logic signed [11:0] exposure_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q     <= 1'b0;
			exposure_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				itml_pkg::REG_INPUT_IS_BYTE: byte_q     <= cfg_data[0];
				itml_pkg::REG_EXPOSURE:      exposure_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// global advance: the pipeline moves while the skid entry is free
	logic en;
	logic skid_valid_q;
	assign en       = !skid_valid_q;
	assign s_tready = en;

	// ---------------- S1: sample to Q.24 ----------------
	logic signed [18:0]   sample;
	logic [24:0]          xb;
	logic signed [XW-1:0] x_in;
	assign sample = $signed(s_tdata[18:0]);
	// round(b * 2^24 / 255) == b * 65793 + (b >= 128)
	assign xb   = 25'(s_tdata[7:0]) * 25'(17'd65793) + 25'(s_tdata[7]);
	assign x_in = byte_q ? $signed(XW'(xb)) : (XW'(sample) <<< XSH);

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [XW-1:0] x_s1, x_s2, x_s3;
	logic signed [X2W-1:0] x2_s2, x2_s3;
	logic signed [X3W-1:0] x3_s3;
	logic                 hi_s2, hi_s3, hi_s4, hi_s5, hi_s6;
	logic signed [PRW-1:0] nx1_s4, nx2_s4, nx3_s4, dx1_s4, dx2_s4, dx3_s4;
	logic signed [SUMW-1:0] nsum_s5, dsum_s5;
	logic signed [NW-1:0]  num_s6;
	logic signed [DNW-1:0] den_s6, den_s7;
	logic signed [PW-1:0]  p_s7;
	logic [PW-1:0]         pm_s8;
	logic [DNW-1:0]        dm_s8, dm_s9;
	itml_pkg::itml_byp_t   byp_s8, byp_s9, byp_nx;
	logic [RMW-1:0]        dnum_s9;

	// combinational stage results
	logic signed [2*XW-1:0]     xe, sq;
	logic signed [X2W+XW-1:0]   cub;
	logic signed [PW-1:0]       p_nx;
	logic                       p_zero, d_zero;
	logic [CMPW-1:0]            cmp_p, cmp_d;

	assign xe  = (2*XW)'(x_s1);
	assign sq  = xe * xe;
	assign cub = (X2W+XW)'(x2_s2) * (X2W+XW)'(x_s2);
	assign p_nx = PW'(itml_pkg::coef(hi_s6, 0)) * PW'(num_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// S8 decisions: sign, zero and division bypass
	always_comb begin
		p_zero = (p_s7 == '0);
		d_zero = (den_s7 == '0);
		byp_nx.bypass = p_zero || d_zero || (p_s7[PW-1] != den_s7[DNW-1]);
		byp_nx.one    = !p_zero && d_zero && !p_s7[PW-1];
	end

	// S9 compare: quotient at or above 1.0 clamps
	assign cmp_p = CMPW'(pm_s8);
	assign cmp_d = CMPW'(dm_s8) << FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			// S1
			x_s1  <= x_in;
			// S2: x^2
			x_s2  <= x_s1;
			hi_s2 <= x_s1 >= BRK;
			x2_s2 <= X2W'(itml_pkg::rnd_shift24(RSW'(sq)));
			// S3: x^3
			x_s3  <= x_s2;
			x2_s3 <= x2_s2;
			hi_s3 <= hi_s2;
			x3_s3 <= X3W'(itml_pkg::rnd_shift24(RSW'(cub)));
			// S4: coefficient products
			hi_s4  <= hi_s3;
			nx1_s4 <= PRW'(itml_pkg::coef(hi_s3, 1)) * PRW'(x_s3);
			nx2_s4 <= PRW'(itml_pkg::coef(hi_s3, 2)) * PRW'(x2_s3);
			nx3_s4 <= PRW'(itml_pkg::coef(hi_s3, 3)) * PRW'(x3_s3);
			dx1_s4 <= PRW'(itml_pkg::coef(hi_s3, 5)) * PRW'(x_s3);
			dx2_s4 <= PRW'(itml_pkg::coef(hi_s3, 6)) * PRW'(x2_s3);
			dx3_s4 <= PRW'(itml_pkg::coef(hi_s3, 7)) * PRW'(x3_s3);
			// S5: sums at Q.48
			hi_s5   <= hi_s4;
			nsum_s5 <= SUMW'(nx1_s4) + SUMW'(nx2_s4) + SUMW'(nx3_s4);
			dsum_s5 <= SUMW'(dx1_s4) + SUMW'(dx2_s4) + SUMW'(dx3_s4);
			// S6: back to Q.24
			hi_s6  <= hi_s5;
			num_s6 <= NW'(itml_pkg::rnd_shift24(RSW'(nsum_s5)));
			den_s6 <= DNW'(itml_pkg::coef(hi_s5, 4))
				+ DNW'(itml_pkg::rnd_shift24(RSW'(dsum_s5)));
			// S7: gain
			p_s7   <= p_nx;
			den_s7 <= den_s6;
			// S8: magnitudes
			pm_s8  <= p_s7[PW-1] ? PW'(-p_s7) : PW'(p_s7);
			dm_s8  <= den_s7[DNW-1] ? DNW'(-den_s7) : DNW'(den_s7);
			byp_s8 <= byp_nx;
			// S9: clamp at one
			dm_s9 <= dm_s8;
			if (!byp_s8.bypass && cmp_p >= cmp_d) begin
				byp_s9.bypass <= 1'b1;
				byp_s9.one    <= 1'b1;
			end else begin
				byp_s9 <= byp_s8;
			end
			dnum_s9 <= (byp_s8.bypass || cmp_p >= cmp_d) ? '0 : RMW'(pm_s8);
		end
	end

	// ---------------- divider ----------------
	logic            v_div;
	logic [FRAC:0]   r_div;

	itml_div #(
		.DEN_W (DNW),
		.QUO_W (FRAC)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.num       (dnum_s9),
		.den       (dm_s9),
		.byp       (byp_s9),
		.out_valid (v_div),
		.ratio     (r_div)
	);

	// ---------------- log10 mapping and exponent ----------------
	logic                  v_s10, v_s11, v_s12, v_s13, v_s14;
	logic [50:0]           lvp_s10;
	logic signed [LVW-1:0] lv_s11;
	logic signed [55:0]    ep_s12;
	logic signed [31:0]    er_s13;
	logic signed [EW-1:0]  e_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s10, v_s11, v_s12, v_s13, v_s14} <= '0;
		end else if (en) begin
			v_s10 <= v_div;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lvp_s10 <= 51'(r_div) * 51'(itml_pkg::RANGE_Q24);
			lv_s11  <= LVW'(itml_pkg::MINV_Q24)
				+ LVW'((lvp_s10 + (51'd1 << (FRAC - 1))) >> FRAC);
			ep_s12  <= 56'(lv_s11) * 56'(itml_pkg::LOG2_10_Q24);
			er_s13  <= 32'(itml_pkg::rnd_shift24(RSW'(ep_s12)));
			e_s14   <= EW'(er_s13) - (EW'(exposure_q) <<< 16);
		end
	end

	// ---------------- exp2 ----------------
	logic                  v_x;
	logic [31:0]           q_x;
	logic signed [NXW-1:0] n_x;

	itml_exp2 #(
		.NXW (NXW)
	) u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s14),
		.frac      (e_s14[FRAC-1:0]),
		.ipart     (e_s14[EW-1:FRAC]),
		.out_valid (v_x),
		.mant      (q_x),
		.ipart_out (n_x)
	);

	// ---------------- output scaling ----------------
	logic signed [11:0] sh;
	logic [11:0]        ks;
	logic [63:0]        wide;
	logic [31:0]        res;
	logic               sat;

	always_comb begin
		sh   = 12'(n_x) + 12'(OUT_FRAC_BITS - 30);
		ks   = 12'(-sh);
		wide = '0;
		sat  = 1'b0;
		if (!sh[11]) begin
			if (sh > 12'sd32) begin
				sat = 1'b1;
			end else begin
				wide = 64'(q_x) << sh[5:0];
				sat  = |wide[63:32];
			end
		end else if (ks < 12'd40) begin
			wide = (64'(q_x) + (64'd1 << (ks - 12'd1))) >> ks;
		end
		res = sat ? '1 : wide[31:0];
	end

	// output register plus one skid entry
	logic        m_valid_q;
	logic [31:0] out_value_q, skid_value_q;
	logic        out_sat_q, skid_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (v_x) begin
			if (m_valid_q && !m_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				m_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_value_q <= skid_value_q;
				out_sat_q   <= skid_sat_q;
			end
		end else if (v_x) begin
			if (m_valid_q && !m_tready) begin
				skid_value_q <= res;
				skid_sat_q   <= sat;
			end else begin
				out_value_q <= res;
				out_sat_q   <= sat;
			end
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = out_value_q;
	assign m_tuser[0] = out_sat_q;

	// ---------------- assertions ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> m_valid_q)
		else $error("skid entry held without a valid output beat");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(m_valid_q && !m_tready))
		else $error("skid filled while output was not stalled");

	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_sat_q) |-> (out_value_q == 32'hFFFF_FFFF))
		else $error("saturated beat without full-scale value");

	a_curve_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_div |-> (r_div <= (FRAC+1)'(itml_pkg::ONE_Q24)))
		else $error("curve value above one after divider");

endmodule

### tb/sv/itml_checker.sv
// ----------------------------------------------------------------------------
// itml_checker: result predictor and scoreboard for the linearizer
// Watches the config port and both stream channels. For every accepted sample
// beat it computes the expected linear value and saturation flag, then
// compares each result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module itml_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [itml_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [itml_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,    // [18:0] sample
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,    // [31:0] linear_value
	input  logic [0:0]  m_tuser,    // [0] saturated
	output int          fails,
	output int          pending,
	output int          checked,
	output int          sat_seen
);

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} lin_result_t;

	localparam longint Q24_ONE   = 64'sd16777216;
	localparam longint KNEE      = 64'sd16663131;
	localparam longint LOG_SPAN  = 64'sd55638642;
	localparam longint LOG_FLOOR = -64'sd36113449;
	localparam longint LOG2_TEN  = 64'sd55732705;
	localparam longint unsigned GREY_Q30 = 64'd193273528;

	localparam longint LO_CURVE [8] = '{
		4109173, -10602534, -71333235, 64453390,
		-83933, -8808212, -14848147, 19346706
	};
	localparam longint HI_CURVE [8] = '{
		8630164, -9282269, -44923931, 48713380,
		-84848, -13504160, -23944221, 34710557
	};
	localparam longint unsigned EXP2_TAYLOR [8] = '{
		744261118, 257941248, 59597083, 10327387,
		1431680, 165394, 16377, 1419
	};

	logic        byte_mode;
	longint      exp_stops;   // Q4.8
	lin_result_t expected_q [$];

	// divide by 2^24, rounding half away from zero
	function automatic longint div24(input longint v);
		longint unsigned mag;
		mag = (v < 0) ? longint'(-v) : v;
		mag = (mag + 64'd8388608) >> 24;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// clamped tone curve value, Q.24 in [0,1]
	function automatic longint tone_curve(input longint x);
		longint c [8];
		longint x2, x3, num, den, p;
		longint unsigned pm, dm;
		if (x < KNEE)
			c = LO_CURVE;
		else
			c = HI_CURVE;
		x2 = div24(x * x);
		x3 = div24(x2 * x);
		num = div24(c[1] * x + c[2] * x2 + c[3] * x3);
		den = c[4] + div24(c[5] * x + c[6] * x2 + c[7] * x3);
		p = c[0] * num;
		if (p == 0)
			return 0;
		if (den == 0)
			return (p > 0) ? Q24_ONE : 0;
		if ((p < 0) != (den < 0))
			return 0;
		pm = (p < 0) ? longint'(-p) : p;
		dm = (den < 0) ? longint'(-den) : den;
		if (pm >= (dm << 24))
			return Q24_ONE;
		return longint'(pm / dm);
	endfunction

	function automatic lin_result_t linearize(input logic [18:0] smp);
		lin_result_t r;
		longint x, lv, e, n, f, sh;
		longint unsigned fq, p, m, q, res;
		int ks;
		if (byte_mode)
			x = longint'(((64'(smp[7:0]) << 24) + 64'd127) / 64'd255);
		else
			x = longint'($signed(smp)) * 256;
		lv = LOG_FLOOR + div24(tone_curve(x) * LOG_SPAN);
		e = div24(lv * LOG2_TEN) - exp_stops * 65536;
		if (e >= 0)
			n = e / Q24_ONE;
		else
			n = -((-e + Q24_ONE - 1) / Q24_ONE);
		f = e - n * Q24_ONE;
		fq = longint'(f) << 6;
		// 2^f by Horner over the Taylor terms, Q.30
		p = EXP2_TAYLOR[7];
		for (int k = 6; k >= 0; k--)
			p = EXP2_TAYLOR[k] + ((p * fq + (64'd1 << 29)) >> 30);
		m = (64'd1 << 30) + ((p * fq + (64'd1 << 29)) >> 30);
		q = (m * GREY_Q30 + (64'd1 << 29)) >> 30;
		sh = n + 20 - 30;
		r.sat = 1'b0;
		res = 0;
		if (sh >= 0) begin
			if (sh > 32) begin
				r.sat = 1'b1;
			end else begin
				res = q << sh;
				if (res > 64'hFFFF_FFFF)
					r.sat = 1'b1;
			end
		end else if (-sh < 40) begin
			ks = int'(-sh);
			res = (q + (64'd1 << (ks - 1))) >> ks;
		end
		r.value = r.sat ? 32'hFFFF_FFFF : res[31:0];
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		$display("mismatch %s: expected %h got %h (beat %0d)", what, want, got, checked);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lin_result_t want;
		if (!arst_n) begin
			byte_mode <= 1'b0;
			exp_stops <= 0;
			expected_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
			sat_seen = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(linearize(s_tdata[18:0]));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report("unexpected beat", 32'h0, m_tdata);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata !== want.value)
						report("linear_value", want.value, m_tdata);
					if (m_tuser[0] !== want.sat)
						report("saturated", 32'(want.sat), 32'(m_tuser));
					if (want.sat)
						sat_seen++;
				end
				checked++;
			end
			if (cfg_we) begin
				if (cfg_index == itml_pkg::REG_INPUT_IS_BYTE)
					byte_mode <= cfg_data[0];
				else if (cfg_index == itml_pkg::REG_EXPOSURE)
					exp_stops <= longint'($signed(cfg_data));
			end
			pending = expected_q.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the inverse tone-map linearizer
// Runs the unit through several mode and exposure settings, with directed
// samples around the curve knee and field extremes, then random beats, under
// random source gaps and sink stalls outside burst phases; the checker scores.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int PHASES    = 8;
	localparam int RAND_BEATS = 50;
	localparam int MAX_WAIT  = 18;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [itml_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [itml_pkg::CFG_DATA_W-1:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [18:0] sample
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] linear_value
	logic [0:0]  m_tuser;   // [0] saturated

	int fails, pending, checked, sat_seen;
	int sent;
	int stall_left;
	logic burst;    // phase with no gaps on either side

	inverse_tone_map_linearizer_unit dut (.*);

	itml_checker chk (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.fails, .pending, .checked, .sat_seen
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sink: after each accepted beat outside a burst, draw a fresh stall length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			if (burst) begin
				m_tready <= 1'b1;
			end else begin
				stall_left <= $urandom_range(0, MAX_WAIT);
				m_tready <= 1'b0;
			end
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [itml_pkg::CFG_IDX_W-1:0] idx,
		input logic [itml_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one sample beat; valid stays up across back-to-back beats
	task automatic push_sample(input logic [18:0] smp);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, smp};
		do @(posedge clk); while (!s_tready);
		sent++;
		gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic        mode [PHASES];
		logic [11:0] expo [PHASES];
		logic [18:0] smp;
		int          pick;
		mode = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		expo = '{12'sd0, 12'sd0, -12'sd2048, 12'sd2047, 12'sd512, -12'sd768, 12'sd0, 12'sd0};
		expo[6] = 12'($urandom);
		expo[7] = 12'($urandom);
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		burst = 1'b0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			// registers change only with the pipe empty
			write_reg(itml_pkg::REG_INPUT_IS_BYTE,
				{{(itml_pkg::CFG_DATA_W-1){1'b0}}, mode[ph]});
			write_reg(itml_pkg::REG_EXPOSURE, expo[ph]);
			burst = (ph % 3 == 2);
			if (ph == 0) begin
				// fixed point: extremes, zero, 1.0 and both sides of the knee
				push_sample(19'h40000);
				push_sample(19'h3FFFF);
				push_sample(19'h00000);
				push_sample(19'h7FFFF);
				push_sample(19'd65536);
				push_sample(19'd65090);
				push_sample(19'd65091);
				push_sample(19'd32768);
				push_sample(19'd6554);
				push_sample(19'h60000);
			end else if (ph == 1) begin
				// byte: ends, knee neighbors, junk in the upper bits
				push_sample(19'd0);
				push_sample(19'd255);
				push_sample(19'd253);
				push_sample(19'd254);
				push_sample(19'd128);
				push_sample(19'd1);
				push_sample(19'h7FF00);
				push_sample(19'h7FFFF);
				push_sample(19'h40080);
			end
			for (int i = 0; i < RAND_BEATS; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					smp = 19'($urandom_range(0, 65600));
				else if (pick < 8)
					smp = 19'($urandom_range(64900, 65300));
				else
					smp = 19'($urandom);
				push_sample(smp);
			end
			drain();
		end

		// the pipe is 48 deep; give stray beats time to show up
		repeat (100) @(posedge clk);
		$display("%0d samples sent over %0d mode/exposure settings, %0d results checked",
			sent, PHASES, checked);
		$display("%0d results hit saturation", sat_seen);
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d results outstanding", pending);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
rtl/itml_pkg.sv
rtl/itml_div.sv
rtl/itml_exp2.sv
rtl/inverse_tone_map_linearizer_unit.sv
tb/sv/itml_checker.sv
tb/sv/tb_top.sv
